/* rtl/steady_state_replacement_macros.svh */
// Assertion macros for the steady-state replacement block.
// Used by rtl/steady_state_replacement.sv; expects clk and rst in scope.
`ifndef STEADY_STATE_REPLACEMENT_MACROS_SVH
`define STEADY_STATE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssr_pkg.sv */
// Shared types and constants of the steady-state replacement block.
// No dependencies; used by rtl/ssr_ram.sv and rtl/steady_state_replacement.sv.
package ssr_pkg;

  localparam int SCORE_W   = 7;
  localparam int RANK_IN_W = 24;
  localparam int GENE_IN_W = 64;
  localparam int INDEX_W   = 5;
  localparam int GEN_W     = 16;
  localparam int PICK_W    = 16;
  localparam int SUM_W     = 12;
  localparam int PICK_CW   = $clog2(PICK_W);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_OFFER = 1'b1;

  localparam logic [1:0] ADDR_RANK_START = 2'd0;

  typedef struct packed {
    logic                 operation;
    logic [INDEX_W-1:0]   entry_index;
    logic [GENE_IN_W-1:0] genotype;
    logic [SCORE_W-1:0]   score;
    logic [RANK_IN_W-1:0] rank_value;
    logic [GEN_W-1:0]     generation;
    logic [PICK_W-1:0]    random_pick;
  } ssr_in_t;

  typedef struct packed {
    logic                 replaced;
    logic [INDEX_W-1:0]   replaced_index;
    logic                 new_best;
    logic                 duplicate;
    logic [SCORE_W-1:0]   best_score_out;
    logic [RANK_IN_W-1:0] best_rank_out;
    logic [INDEX_W-1:0]   best_slot;
    logic [SUM_W-1:0]     score_total;
  } ssr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_PICK,
    ST_COMMIT
  } ssr_state_t;

endpackage

/* rtl/ssr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on ssr_pkg only through the project import convention.
module ssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import ssr_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/steady_state_replacement.sv */
// Steady-state replacement block: population table with best tracking.
// Depends on ssr_pkg, ssr_ram and steady_state_replacement_macros.svh.
//
// Usage:
//   Input channel: drive item and raise start; the transfer happens on a
//   clock edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with result valid; the
//   receiver cannot stall, so capture result whenever done is high.
//   Config: APB-style port, one register (rank_start_generation) at
//   address 0; pready is tied high. Write only while the block is idle.
// Timing:
//   A load finishes at its own transfer edge: done follows in the next
//   cycle and busy never rises, so loads run at one per cycle.
//   An offer walks the table once through the entry RAM read port, runs
//   a 16-step restoring remainder for the random pick, reads the picked
//   entry of the list of worse slots and writes the winner; done rises
//   as busy falls. A duplicate or a child with no worse entry ends after
//   the scan, without running the remainder.
// Reset: synchronous, active high; best score to GENE_BITS, best rank to all
//   ones, best slot, score sum and config cleared. Table undefined until loaded.
`include "steady_state_replacement_macros.svh"

module steady_state_replacement #(
  parameter int POP_SIZE  = 32,
  parameter int GENE_BITS = 64,
  parameter int RANK_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ssr_pkg::ssr_in_t item,
  output logic             done,
  output ssr_pkg::ssr_out_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ssr_pkg::*;

  localparam int IW = $clog2(POP_SIZE);      // slot index width
  localparam int CW = $clog2(POP_SIZE + 1);  // counter that can hold POP_SIZE
  localparam int EW = GENE_BITS + SCORE_W + RANK_BITS;
  localparam int LW = IW + SCORE_W;          // worse-list entry: slot and score

  // Control and datapath registers.
  ssr_state_t             state, state_next;
  logic [CW-1:0]          k, k_next;
  logic [IW-1:0]          eval_idx, eval_idx_next;
  logic [CW-1:0]          wcount, wcount_next;
  logic                   dup_flag, dup_flag_next;
  logic                   hit_flag, hit_flag_next;
  logic                   use_rank, use_rank_next;
  logic [GENE_BITS-1:0]   cur_gene, cur_gene_next;
  logic [SCORE_W-1:0]     cur_score, cur_score_next;
  logic [RANK_BITS-1:0]   child_rank, child_rank_next;
  logic [PICK_W-1:0]      pick_sh, pick_sh_next;
  logic [PICK_CW-1:0]     bit_cnt, bit_cnt_next;
  logic [CW-1:0]          rem, rem_next;
  logic [SCORE_W-1:0]     top_score, top_score_next;
  logic [RANK_BITS-1:0]   top_rank, top_rank_next;
  logic [IW-1:0]          best_slot, best_slot_next;
  logic [SUM_W-1:0]       score_sum, score_sum_next;
  logic [GEN_W-1:0]       rank_start;
  logic                   done_next;
  ssr_out_t               result_next;

  // Input item, trimmed to stored widths.
  logic [GENE_BITS-1:0]   in_gene;
  logic [RANK_BITS-1:0]   in_rank;
  logic                   in_beats_best;
  logic                   accept;
  logic                   offer_accept;
  logic                   load_accept;

  // Entry RAM ports.
  logic                   e_we;
  logic [IW-1:0]          e_waddr;
  logic [EW-1:0]          e_wdata;
  logic [EW-1:0]          e_rdata;
  logic [GENE_BITS-1:0]   rd_gene;
  logic [SCORE_W-1:0]     rd_score;
  logic [RANK_BITS-1:0]   rd_rank;

  // Worse-list RAM ports.
  logic                   w_we;
  logic [LW-1:0]          w_rdata;
  logic [IW-1:0]          pick_slot;
  logic [SCORE_W-1:0]     pick_old_score;

  // Remainder unit.
  logic [CW:0]            rem_shift;
  logic                   rem_ge;

  // Scan compare.
  logic                   entry_worse;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign offer_accept = accept && (item.operation == OP_OFFER);
  assign load_accept  = accept && (item.operation == OP_LOAD);
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RANK_START) ? 32'(rank_start) : '0;

  assign in_gene = item.genotype[GENE_BITS-1:0];
  assign in_rank = RANK_BITS'(item.rank_value);
  assign in_beats_best = (item.score < top_score) ||
                         ((item.score == top_score) && (in_rank < top_rank));

  assign rd_gene  = e_rdata[EW-1 -: GENE_BITS];
  assign rd_score = e_rdata[RANK_BITS +: SCORE_W];
  assign rd_rank  = e_rdata[RANK_BITS-1:0];

  // Entry is worse than the child: higher score, or equal score with a higher
  // rank once the generation has reached the rank start.
  assign entry_worse = use_rank ?
                       ((cur_score < rd_score) ||
                        ((cur_score == rd_score) && (child_rank < rd_rank))) :
                       (cur_score < rd_score);

  assign pick_slot      = w_rdata[LW-1 -: IW];
  assign pick_old_score = w_rdata[SCORE_W-1:0];

  // One restoring step: shift in the next pick bit, subtract when it fits.
  assign rem_shift = {rem, pick_sh[PICK_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, wcount});

  ssr_ram #(
    .WIDTH (EW),
    .DEPTH (POP_SIZE)
  ) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (k[IW-1:0]),
    .rdata (e_rdata)
  );

  ssr_ram #(
    .WIDTH (LW),
    .DEPTH (POP_SIZE)
  ) u_worse_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (wcount[IW-1:0]),
    .wdata ({eval_idx, rd_score}),
    .raddr (rem[IW-1:0]),
    .rdata (w_rdata)
  );

  // Config register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_start <= '0;
    end else if (psel && penable && pwrite && pready) begin
      rank_start <= pwdata[GEN_W-1:0];
    end
  end

  // Next state, datapath and result.
  always_comb begin
    state_next      = state;
    k_next          = k;
    eval_idx_next   = eval_idx;
    wcount_next     = wcount;
    dup_flag_next   = dup_flag;
    hit_flag_next   = hit_flag;
    use_rank_next   = use_rank;
    cur_gene_next   = cur_gene;
    cur_score_next  = cur_score;
    child_rank_next = child_rank;
    pick_sh_next    = pick_sh;
    bit_cnt_next    = bit_cnt;
    rem_next        = rem;
    top_score_next  = top_score;
    top_rank_next   = top_rank;
    best_slot_next  = best_slot;
    score_sum_next  = score_sum;
    done_next       = 1'b0;
    result_next     = result;
    e_we            = 1'b0;
    e_waddr         = IW'(item.entry_index);
    e_wdata         = {in_gene, item.score, in_rank};
    w_we            = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept && item.operation == OP_LOAD) begin
          // Load: write the slot, add the score, maybe take over the best.
          result_next.replaced       = 1'b0;
          result_next.replaced_index = '0;
          result_next.duplicate      = 1'b0;
          result_next.new_best       = 1'b0;
          done_next                  = 1'b1;
          if (int'(item.entry_index) < POP_SIZE) begin
            e_we           = 1'b1;
            score_sum_next = score_sum + SUM_W'(item.score);
            if (in_beats_best) begin
              top_score_next       = item.score;
              top_rank_next        = in_rank;
              best_slot_next       = IW'(item.entry_index);
              result_next.new_best = 1'b1;
            end
          end
        end else if (accept) begin
          // Offer: capture the child, settle the best score and rank now, start the scan.
          cur_gene_next   = in_gene;
          cur_score_next  = item.score;
          child_rank_next = in_rank;
          pick_sh_next    = item.random_pick;
          use_rank_next   = (item.generation >= rank_start);
          hit_flag_next   = in_beats_best;
          if (in_beats_best) begin
            top_score_next = item.score;
            top_rank_next  = in_rank;
          end
          dup_flag_next = 1'b0;
          wcount_next   = '0;
          k_next        = '0;
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue read of slot k; data for slot k-1 is on e_rdata.
        eval_idx_next = k[IW-1:0];
        k_next        = k + 1'b1;
        if (k != '0) begin
          if (!hit_flag && rd_gene == cur_gene) begin
            dup_flag_next = 1'b1;
          end
          if (entry_worse) begin
            w_we        = 1'b1;
            wcount_next = wcount + 1'b1;
          end
        end
        if (k == CW'(POP_SIZE)) begin
          rem_next     = '0;
          bit_cnt_next = '0;
          state_next   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (dup_flag || wcount == '0) begin
          // Drop the child.
          result_next.replaced       = 1'b0;
          result_next.replaced_index = '0;
          result_next.new_best       = hit_flag;
          result_next.duplicate      = dup_flag;
          done_next                  = 1'b1;
          state_next                 = ST_IDLE;
        end else begin
          rem_next     = rem_ge ? CW'(rem_shift - {1'b0, wcount}) : CW'(rem_shift);
          pick_sh_next = {pick_sh[PICK_W-2:0], 1'b0};
          bit_cnt_next = bit_cnt + 1'b1;
          if (bit_cnt == PICK_CW'(PICK_W - 1)) begin
            state_next = ST_PICK;
          end
        end
      end

      ST_PICK: begin
        // Worse-list read at rem is in flight.
        state_next = ST_COMMIT;
      end

      ST_COMMIT: begin
        e_we           = 1'b1;
        e_waddr        = pick_slot;
        e_wdata        = {cur_gene, cur_score, child_rank};
        score_sum_next = score_sum - SUM_W'(pick_old_score) + SUM_W'(cur_score);
        if (hit_flag) begin
          best_slot_next = pick_slot;
        end
        result_next.replaced       = 1'b1;
        result_next.replaced_index = INDEX_W'(pick_slot);
        result_next.new_best       = hit_flag;
        result_next.duplicate      = 1'b0;
        done_next                  = 1'b1;
        state_next                 = ST_IDLE;
      end
    endcase

    result_next.best_score_out = top_score_next;
    result_next.best_rank_out  = RANK_IN_W'(top_rank_next);
    result_next.best_slot      = INDEX_W'(best_slot_next);
    result_next.score_total    = score_sum_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      top_score <= SCORE_W'(GENE_BITS);
      top_rank  <= '1;
      best_slot <= '0;
      score_sum <= '0;
    end else begin
      state     <= state_next;
      done      <= done_next;
      top_score <= top_score_next;
      top_rank  <= top_rank_next;
      best_slot <= best_slot_next;
      score_sum <= score_sum_next;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    k          <= k_next;
    eval_idx   <= eval_idx_next;
    wcount     <= wcount_next;
    dup_flag   <= dup_flag_next;
    hit_flag   <= hit_flag_next;
    use_rank   <= use_rank_next;
    cur_gene   <= cur_gene_next;
    cur_score  <= cur_score_next;
    child_rank <= child_rank_next;
    pick_sh    <= pick_sh_next;
    bit_cnt    <= bit_cnt_next;
    rem        <= rem_next;
    result     <= result_next;
  end

  `SSR_ASSERT_NEXT(a_offer_goes_busy, offer_accept, busy, "offer did not start a search")
  `SSR_ASSERT_NEXT(a_load_one_cycle, load_accept, done && !busy, "load result missing")
  `SSR_ASSERT_NOW(a_rep_no_dup, done && result.replaced, !result.duplicate, "dup replaced")
  `SSR_ASSERT_NOW(a_drop_index, done && !result.replaced, result.replaced_index == '0, "index set")

endmodule
